@@ sv/ile_pkg.sv @@
// Package for the indexed list engine: beat structs, operation and status codes,
// state machine and cell command types. No dependencies.
package ile_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int DATA_WIDTH_DEF = 64;
    localparam int WORD_W         = 64;
    localparam int IDX_W          = 10;
    localparam int CAP_W          = 11;

    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_BACK   = 3'd2,
        OP_GET    = 3'd3,
        OP_SET    = 3'd4,
        OP_INSERT = 3'd5,
        OP_REMOVE = 3'd6,
        OP_CLEAR  = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_OOB   = 2'd1,
        STS_EMPTY = 2'd2,
        STS_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        CM_NONE,
        CM_WRITE,
        CM_SHR,
        CM_SHL
    } t_cell_mode;

    typedef struct packed {
        logic [2:0]        operation;
        logic [IDX_W-1:0]  index;
        logic [WORD_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [WORD_W-1:0] read_value;
        logic [CAP_W-1:0]  element_count;
        logic              is_empty;
    } t_out;

endpackage

@@ sv/ile_cell.sv @@
// One storage cell of the list row: holds one element and one stage of the read lane.
// Depends on ile_pkg.
module ile_cell #(
    parameter int DATA_WIDTH = ile_pkg::DATA_WIDTH_DEF,
    parameter int PW         = 10,
    parameter int POS        = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ile_pkg::t_cell_mode    i_mode,
    input  logic [PW-1:0]          i_target,
    input  logic [DATA_WIDTH-1:0]  i_value,
    input  logic [DATA_WIDTH-1:0]  i_left,
    input  logic [DATA_WIDTH-1:0]  i_right,
    output logic [DATA_WIDTH-1:0]  o_data,
    input  logic                   i_lane_vld,
    input  logic [PW-1:0]          i_lane_addr,
    input  logic [DATA_WIDTH-1:0]  i_lane_data,
    output logic                   o_lane_vld,
    output logic [PW-1:0]          o_lane_addr,
    output logic [DATA_WIDTH-1:0]  o_lane_data
);
    import ile_pkg::*;

    localparam logic [PW-1:0] POS_V = PW'(POS);

    logic [DATA_WIDTH-1:0] r_data;
    logic                  r_lane_vld;
    logic [PW-1:0]         r_lane_addr;
    logic [DATA_WIDTH-1:0] r_lane_data;

    // element: write in place, or take a neighbour's word on a shift
    always_ff @(posedge i_clk) begin
        case (i_mode)
            CM_WRITE: begin
                if (i_target == POS_V) r_data <= i_value;
            end
            CM_SHR: begin
                if (POS_V > i_target) r_data <= i_left;
                else if (POS_V == i_target) r_data <= i_value;
            end
            CM_SHL: begin
                if (POS_V >= i_target) r_data <= i_right;
            end
            default: ;
        endcase
    end

    // read lane: pass the beat on, dropping in our word at the addressed cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_vld <= 1'b0;
        end else begin
            r_lane_vld <= i_lane_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane_addr <= i_lane_addr;
        r_lane_data <= (i_lane_addr == POS_V) ? r_data : i_lane_data;
    end

    assign o_data      = r_data;
    assign o_lane_vld  = r_lane_vld;
    assign o_lane_addr = r_lane_addr;
    assign o_lane_data = r_lane_data;

endmodule

@@ sv/indexed_list_engine_unit.sv @@
// Indexed list engine: ordered list of words held in a row of DEPTH cells.
// Push, set, insert, remove, clear and failed reads commit their result from the execute
// state; pop, back and get first send a beat down the read lane, which walks one cell per
// cycle, and commit from the done state. One item is in work at a time: a new input beat
// is taken once the last item has committed, later while a result beat waits to be taken.
// Reset (synchronous, active low) empties the list and sets the capacity to DEPTH.
module indexed_list_engine_unit #(
    parameter int DEPTH      = ile_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ile_pkg::DATA_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  ile_pkg::t_in              i_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output ile_pkg::t_out             o_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [ile_pkg::CAP_W-1:0] i_cfg_data
);
    import ile_pkg::*;

    localparam int PW = $clog2(DEPTH);       // cell position width
    localparam int CW = $clog2(DEPTH + 1);   // count and capacity width
    localparam int KW = (CW > CAP_W) ? CW : CAP_W;  // compare width

    // control registers
    t_state         r_state, n_state;
    t_in            r_item;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  r_cap;
    logic [DATA_WIDTH-1:0] r_rd;
    logic           r_out_vld;
    t_out           r_out;

    // decode of the held item
    t_status        op_status;
    t_cell_mode     op_mode;
    logic [KW-1:0]  op_target;
    logic [KW-1:0]  op_count;
    logic           read_ok;

    // handshake and sequencing
    logic           out_free;
    logic           commit;
    logic           lane_inject;
    t_cell_mode     cell_mode;

    // cell row wiring: entry g+1 is cell g; the two ends of w_data are tied to zero
    logic [DATA_WIDTH-1:0] w_data      [DEPTH+2];
    logic                  w_lane_vld  [DEPTH+1];
    logic [PW-1:0]         w_lane_addr [DEPTH+1];
    logic [DATA_WIDTH-1:0] w_lane_data [DEPTH+1];

    logic [KW-1:0] cnt_k, idx_k, cap_k, cfg_k, cfg_lim;
    logic          full;

    assign cnt_k = KW'(r_count);
    assign idx_k = KW'(r_item.index);
    assign cap_k = KW'(r_cap);
    assign full  = (cnt_k >= cap_k);

    // work out status, count after the operation and the cell command
    always_comb begin
        op_status = STS_OK;
        op_mode   = CM_NONE;
        op_target = cnt_k;
        op_count  = cnt_k;
        read_ok   = 1'b0;
        case (t_op'(r_item.operation))
            OP_PUSH: begin
                if (full) begin
                    op_status = STS_FULL;
                end else begin
                    op_mode  = CM_WRITE;
                    op_count = cnt_k + KW'(1);
                end
            end
            OP_POP, OP_BACK: begin
                op_target = cnt_k - KW'(1);
                if (cnt_k == '0) begin
                    op_status = STS_EMPTY;
                end else begin
                    read_ok = 1'b1;
                    if (t_op'(r_item.operation) == OP_POP) op_count = cnt_k - KW'(1);
                end
            end
            OP_GET, OP_SET: begin
                op_target = idx_k;
                if (idx_k >= cnt_k) begin
                    op_status = STS_OOB;
                end else if (t_op'(r_item.operation) == OP_GET) begin
                    read_ok = 1'b1;
                end else begin
                    op_mode = CM_WRITE;
                end
            end
            OP_INSERT: begin
                op_target = idx_k;
                if (idx_k > cnt_k) begin
                    op_status = STS_OOB;
                end else if (full) begin
                    op_status = STS_FULL;
                end else begin
                    op_mode  = CM_SHR;
                    op_count = cnt_k + KW'(1);
                end
            end
            OP_REMOVE: begin
                op_target = idx_k;
                if (idx_k >= cnt_k) begin
                    op_status = STS_OOB;
                end else begin
                    op_mode  = CM_SHL;
                    op_count = cnt_k - KW'(1);
                end
            end
            OP_CLEAR: begin
                op_count = '0;
            end
            default: ;
        endcase
    end

    // output register is free when empty or being drained this cycle
    assign out_free = !r_out_vld || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (read_ok) n_state = S_READ;
                else if (out_free) n_state = S_IDLE;
            end
            S_READ: begin
                if (w_lane_vld[DEPTH]) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state machine outputs
    always_comb begin
        o_ready     = 1'b0;
        commit      = 1'b0;
        lane_inject = 1'b0;
        cell_mode   = CM_NONE;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
            end
            S_EXEC: begin
                if (read_ok) begin
                    lane_inject = 1'b1;
                end else if (out_free) begin
                    commit    = 1'b1;
                    cell_mode = op_mode;
                end
            end
            S_DONE: begin
                commit = out_free;
            end
            default: ;
        endcase
    end

    assign o_cfg_ready = 1'b1;

    // capacity write: ignore zero, saturate at DEPTH
    assign cfg_k   = KW'(i_cfg_data);
    assign cfg_lim = (cfg_k > KW'(DEPTH)) ? KW'(DEPTH) : cfg_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cap     <= CW'(DEPTH);
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && (cfg_k != '0)) begin
                r_cap <= CW'(cfg_lim);
                if (cnt_k > cfg_lim) r_count <= CW'(cfg_lim);
            end else if (commit) begin
                r_count <= CW'(op_count);
            end
            if (commit) r_out_vld <= 1'b1;
            else if (i_ready) r_out_vld <= 1'b0;
        end
    end

    // payload registers: item, read word and result beat
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) r_item <= i_data;
        if ((r_state == S_READ) && w_lane_vld[DEPTH]) r_rd <= w_lane_data[DEPTH];
        if (commit) begin
            r_out.status        <= op_status;
            r_out.read_value    <= read_ok ? WORD_W'(r_rd) : '0;
            r_out.element_count <= CAP_W'(op_count);
            r_out.is_empty      <= (op_count == '0);
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // the cell row
    assign w_data[0]       = '0;
    assign w_data[DEPTH+1] = '0;
    assign w_lane_vld[0]   = lane_inject;
    assign w_lane_addr[0]  = PW'(op_target);
    assign w_lane_data[0]  = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        ile_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .PW         (PW),
            .POS        (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_mode      (cell_mode),
            .i_target    (PW'(op_target)),
            .i_value     (r_item.value[DATA_WIDTH-1:0]),
            .i_left      (w_data[g]),
            .i_right     (w_data[g+2]),
            .o_data      (w_data[g+1]),
            .i_lane_vld  (w_lane_vld[g]),
            .i_lane_addr (w_lane_addr[g]),
            .i_lane_data (w_lane_data[g]),
            .o_lane_vld  (w_lane_vld[g+1]),
            .o_lane_addr (w_lane_addr[g+1]),
            .o_lane_data (w_lane_data[g+1])
        );
    end

    // count never runs past the capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("count above capacity");

    // a read beat leaves the lane only while a read is awaited
    a_lane_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lane_vld[DEPTH] |-> (r_state == S_READ))
        else $error("stray read lane beat");

    // a fresh result always follows a commit
    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(commit))
        else $error("result without commit");

    // a commit never overwrites a result still waiting
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |-> (!r_out_vld || i_ready))
        else $error("result overrun");

endmodule

@@ verif/ile_checker.sv @@
`timescale 1ns / 100ps
// Checker for the indexed list engine: watches the request, response and capacity channels,
// keeps its own copy of the list and compares every response beat. Depends on ile_pkg.
module ile_checker #(
    parameter int DEPTH      = ile_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ile_pkg::DATA_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    input  logic                      i_req_ready,
    input  ile_pkg::t_in              i_req,
    input  logic                      i_rsp_valid,
    input  logic                      i_rsp_ready,
    input  ile_pkg::t_out             i_rsp,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [ile_pkg::CAP_W-1:0] i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);
    import ile_pkg::*;

    localparam logic [WORD_W-1:0] WORD_MASK =
        (DATA_WIDTH >= WORD_W) ? {WORD_W{1'b1}} : ((64'd1 << DATA_WIDTH) - 64'd1);

    logic [WORD_W-1:0] list_words [DEPTH];
    int                list_len;
    int                cap_limit;
    t_out              list_replies [$];
    int                mismatch_total;

    // Capacity of zero is ignored; anything above DEPTH saturates.
    task automatic set_capacity(input logic [CAP_W-1:0] raw);
        int lim;
        lim = raw;
        if (lim == 0)
            return;
        if (lim > DEPTH)
            lim = DEPTH;
        cap_limit = lim;
        if (list_len > lim)
            list_len = lim;
    endtask

    function automatic t_out run_list_op(input t_in req);
        t_out              rsp;
        t_op               op;
        int                idx;
        logic [WORD_W-1:0] word;
        rsp  = '0;
        op   = t_op'(req.operation);
        idx  = req.index;
        word = req.value & WORD_MASK;
        rsp.status = STS_OK;
        case (op)
            OP_PUSH: begin
                if (list_len >= cap_limit || list_len >= DEPTH) begin
                    rsp.status = STS_FULL;
                end else begin
                    list_words[list_len] = word;
                    list_len++;
                end
            end
            OP_POP, OP_BACK: begin
                if (list_len == 0) begin
                    rsp.status = STS_EMPTY;
                end else begin
                    rsp.read_value = list_words[list_len-1];
                    if (op == OP_POP)
                        list_len--;
                end
            end
            OP_GET, OP_SET: begin
                if (idx >= list_len || idx >= DEPTH)
                    rsp.status = STS_OOB;
                else if (op == OP_GET)
                    rsp.read_value = list_words[idx];
                else
                    list_words[idx] = word;
            end
            OP_INSERT: begin
                // index range is checked before the full check
                if (idx > list_len) begin
                    rsp.status = STS_OOB;
                end else if (list_len >= cap_limit || list_len >= DEPTH) begin
                    rsp.status = STS_FULL;
                end else begin
                    for (int k = list_len; k > idx; k--)
                        list_words[k] = list_words[k-1];
                    list_words[idx] = word;
                    list_len++;
                end
            end
            OP_REMOVE: begin
                if (idx >= list_len || idx >= DEPTH) begin
                    rsp.status = STS_OOB;
                end else begin
                    for (int k = idx; k < list_len - 1; k++)
                        list_words[k] = list_words[k+1];
                    list_len--;
                end
            end
            default: begin
                list_len = 0;
            end
        endcase
        rsp.element_count = list_len[CAP_W-1:0];
        rsp.is_empty      = (list_len == 0);
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            list_len       = 0;
            cap_limit      = DEPTH;
            mismatch_total = 0;
            list_replies.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                set_capacity(i_cfg_data);
            if (i_rsp_valid && i_rsp_ready) begin
                if (list_replies.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= 10)
                        $display("%0t: unexpected response beat sts=%0d rd=%h cnt=%0d empty=%0b",
                                 $realtime, i_rsp.status, i_rsp.read_value,
                                 i_rsp.element_count, i_rsp.is_empty);
                end else begin
                    want = list_replies.pop_front();
                    if (i_rsp.status !== want.status || i_rsp.read_value !== want.read_value
                        || i_rsp.element_count !== want.element_count
                        || i_rsp.is_empty !== want.is_empty) begin
                        mismatch_total++;
                        if (mismatch_total <= 10)
                            $display({"%0t: mismatch sts exp %0d got %0d, rd exp %h got %h,",
                                      " cnt exp %0d got %0d, empty exp %0b got %0b"},
                                     $realtime, want.status, i_rsp.status,
                                     want.read_value, i_rsp.read_value,
                                     want.element_count, i_rsp.element_count,
                                     want.is_empty, i_rsp.is_empty);
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                list_replies.push_back(run_list_op(i_req));
        end
        o_fail_count <= mismatch_total;
        o_pending    <= list_replies.size();
    end

endmodule

@@ verif/indexed_list_engine_unit_tb.sv @@
`timescale 1ns / 100ps
// Top of the indexed list engine testbench: clock, reset, request and capacity stimulus,
// response back-pressure and the verdict. Depends on ile_pkg, ile_checker and the engine.
module indexed_list_engine_unit_tb;
    import ile_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int DATA_WIDTH   = DATA_WIDTH_DEF;
    localparam int PHASES       = 7;
    localparam int PHASE_BEATS  = 140;
    localparam int LONG_HOLD    = 400;
    // Worst case is every beat a successful read, walking the whole read lane, plus gaps and
    // stalls, taken about three times over.
    localparam int LIMIT_CYCLES = 4_000_000;

    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_PATTERN
    } t_rx_mode;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_ready;
    t_in              req_beat  = '0;
    logic             rsp_valid;
    logic             rsp_ready = 1'b0;
    t_out             rsp_beat;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data  = '0;

    int               fail_count;
    int               pending;
    int               burst_left = 0;
    int               cycle_count = 0;
    int               hold_seq = 0;
    int               hold_seen = 0;
    int               hold_left = 0;
    int               stretch_left = 0;
    t_rx_mode         rx_mode = RX_OPEN;
    logic [7:0]       rx_pattern = 8'hFF;

    indexed_list_engine_unit #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (req_valid),
        .o_ready     (req_ready),
        .i_data      (req_beat),
        .o_valid     (rsp_valid),
        .i_ready     (rsp_ready),
        .o_data      (rsp_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    ile_checker #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) list_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req        (req_beat),
        .i_rsp_valid  (rsp_valid),
        .i_rsp_ready  (rsp_ready),
        .i_rsp        (rsp_beat),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Response side back-pressure. Work in stretches of random length, each with its own
    // mode: always open, random stalls, or a rotating stall pattern. A long hold-off
    // requested by the stimulus overrides all of them and is counted down here.
    always @(posedge clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
        end else begin
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(16, 160);
                rx_mode      = t_rx_mode'($urandom_range(0, 2));
                rx_pattern   = 8'($urandom) | 8'h01;
            end
            stretch_left--;
            case (rx_mode)
                RX_OPEN: begin
                    rsp_ready <= 1'b1;
                end
                RX_RANDOM: begin
                    rsp_ready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    rsp_ready  <= rx_pattern[0];
                    rx_pattern  = {rx_pattern[0], rx_pattern[7:1]};
                end
            endcase
        end
    end

    function automatic t_in make_req(input t_op op, input int idx, input logic [WORD_W-1:0] val);
        t_in req;
        req.operation = op;
        req.index     = idx[IDX_W-1:0];
        req.value     = val;
        return req;
    endfunction

    // Offer one request beat. Bursts of random length are separated by random gaps;
    // inside a burst valid stays high and only the payload advances.
    task automatic send_req(input t_in req);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(1, 12);
            burst_left = $urandom_range(1, 60);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        req_valid <= 1'b1;
        req_beat  <= req;
        do @(posedge clk); while (!(req_valid && req_ready));
    endtask

    // Drop valid and hold until every outstanding response beat has been taken.
    task automatic drain_list();
        req_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // Capacity is only written with the engine idle.
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain_list();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    // Weighted operation mix: growth slightly outweighs shrinking so the list builds up,
    // with the occasional clear to start over.
    function automatic t_op pick_op();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 20)
            return OP_PUSH;
        if (roll < 28)
            return OP_POP;
        if (roll < 32)
            return OP_BACK;
        if (roll < 42)
            return OP_GET;
        if (roll < 56)
            return OP_SET;
        if (roll < 74)
            return OP_INSERT;
        if (roll < 98)
            return OP_REMOVE;
        return OP_CLEAR;
    endfunction

    // Mostly indices near the front, where the list actually has elements; now and then
    // anywhere in the full index range.
    function automatic t_in random_req();
        int                roll;
        int                idx;
        logic [WORD_W-1:0] val;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            idx = $urandom_range(0, (1 << IDX_W) - 1);
        else if (roll < 40)
            idx = $urandom_range(0, 8);
        else
            idx = $urandom_range(0, 40);
        roll = $urandom_range(0, 9);
        if (roll == 0)
            val = '0;
        else if (roll == 1)
            val = '1;
        else
            val = {$urandom, $urandom};
        return make_req(pick_op(), idx, val);
    endfunction

    function automatic logic [CAP_W-1:0] capacity_for_phase(input int phase);
        case (phase)
            0:       return CAP_W'(DEPTH);
            1:       return 11'd1;
            2:       return CAP_W'($urandom_range(2, 8));
            3:       return CAP_W'($urandom_range(9, 64));
            4:       return 11'd2047;
            5:       return CAP_W'($urandom_range(1, 1023));
            default: return CAP_W'(DEPTH);
        endcase
    endfunction

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list: every read and indexed operation must fail.
        send_req(make_req(OP_POP, 0, '0));
        send_req(make_req(OP_BACK, 0, '0));
        send_req(make_req(OP_GET, 0, '0));
        send_req(make_req(OP_SET, 1023, '1));
        send_req(make_req(OP_REMOVE, 0, '0));
        send_req(make_req(OP_INSERT, 1, '1));
        // Build a short list, then walk shifts in both directions.
        send_req(make_req(OP_INSERT, 0, '1));
        send_req(make_req(OP_PUSH, 0, '0));
        send_req(make_req(OP_PUSH, 0, 64'hA5A5_5A5A_0F0F_F0F0));
        send_req(make_req(OP_GET, 0, '0));
        send_req(make_req(OP_SET, 1, 64'h8000_0000_0000_0001));
        // insert at an index equal to the count appends
        send_req(make_req(OP_INSERT, 3, 64'h0123_4567_89AB_CDEF));
        send_req(make_req(OP_INSERT, 1, 64'hFEDC_BA98_7654_3210));
        send_req(make_req(OP_GET, 1023, '0));
        send_req(make_req(OP_REMOVE, 0, '0));
        send_req(make_req(OP_REMOVE, 3, '0));
        send_req(make_req(OP_BACK, 0, '0));
        send_req(make_req(OP_POP, 0, '0));
        send_req(make_req(OP_CLEAR, 0, '0));

        // Small capacity: fill it, then push and insert past it.
        write_capacity(11'd2);
        send_req(make_req(OP_PUSH, 0, 64'h0000_0000_0000_0011));
        send_req(make_req(OP_PUSH, 0, 64'h0000_0000_0000_0022));
        send_req(make_req(OP_PUSH, 0, 64'h0000_0000_0000_0033));
        send_req(make_req(OP_INSERT, 0, 64'h0000_0000_0000_0044));
        // out-of-range insert index wins over full
        send_req(make_req(OP_INSERT, 3, 64'h0000_0000_0000_0055));
        // lowering the capacity below the count clamps the count
        write_capacity(11'd1);
        send_req(make_req(OP_BACK, 0, '0));
        // a zero capacity is ignored, so the list stays full at one
        write_capacity(11'd0);
        send_req(make_req(OP_PUSH, 0, 64'h0000_0000_0000_0066));
        // an oversized capacity saturates to the depth
        write_capacity(11'd2047);
        send_req(make_req(OP_PUSH, 0, 64'h0000_0000_0000_0077));

        // Random phases, each under its own capacity. Two of them start with a long
        // response hold-off so the engine backs up and stalls its request side.
        for (int phase = 0; phase < PHASES; phase++) begin
            write_capacity(capacity_for_phase(phase));
            if (phase == 2 || phase == 5)
                hold_seq++;
            for (int n = 0; n < PHASE_BEATS; n++)
                send_req(random_req());
        end

        // Let the last responses out, then give any late beat time to show up.
        drain_list();
        repeat (DEPTH + 8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
